@@ rtl/assert_macros.svh @@
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/s512_pkg.sv @@
// Package: SHA-512 types, constants and round functions.
package s512_pkg;
    typedef logic [63:0] t_word;
    typedef t_word t_hash [8];

    localparam int BLOCK_BYTES = 128;
    localparam int LEN_POS = 112;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word init_word(input logic [2:0] idx);
        t_word r;
        unique case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic t_word round_k(input logic [6:0] idx);
        t_word r;
        unique case (idx)
            7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
            7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
            7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
            7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
            7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec; default: r = 64'h6c44198c4a475817;
        endcase
        return r;
    endfunction

    function automatic t_word rotr(input t_word x, input int s);
        return (x >> s) | (x << (64 - s));
    endfunction

    // commands from controller to datapath
    typedef struct packed {
        logic       put;       // write byte at fill position
        logic [7:0] put_byte;
        logic       count;     // bump message byte count
        logic       start;     // begin compression of buffer
        logic       round;     // run one round
        logic       fold;      // add working vars into chaining words
        logic       shift_out; // rotate chaining words by one for output
        logic       reinit;    // restore initial values, clear count
    } t_cmd;

    typedef struct packed {
        logic [6:0]  fill;
        logic        full;
        logic [63:0] bits;
    } t_stat;
endpackage

@@ rtl/s512_if.sv @@
// Valid/ready stream interfaces for input bytes and digest words.
interface s512_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface s512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/s512_datapath.sv @@
// Datapath: block buffer, message schedule, round unit and chaining words.
module s512_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  s512_pkg::t_cmd i_cmd,
    input  logic [6:0]     i_round,
    output s512_pkg::t_stat o_stat,
    output logic [63:0]    o_head
);
    import s512_pkg::*;

    logic [6:0]  r_fill;
    logic        r_full;
    logic [63:0] r_cnt;
    t_hash       r_h;
    t_hash       r_v;
    t_word       r_w [16];
    t_hash       n_v;
    t_word       n_w, t1, t2, wi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_full <= 1'b0;
            if (i_cmd.put) begin
                r_fill <= r_fill + 7'd1;
                r_full <= (r_fill == 7'(BLOCK_BYTES - 1));
            end
            if (i_cmd.reinit) begin
                r_cnt <= '0;
                r_fill <= '0;
            end else if (i_cmd.count) begin
                r_cnt <= r_cnt + 64'd1;
            end
        end
    end

    // schedule word for this round: load from buffer or extend
    always_comb begin
        t_word s0, s1;
        s0 = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        s1 = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        n_w = r_w[0] + s0 + r_w[9] + s1;
        wi = (i_round < 7'd16) ? r_w[0] : n_w;
    end

    always_comb begin
        t_word b1, ch, b0, mj;
        b1 = rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        b0 = rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + b1 + ch + round_k(i_round) + wi;
        t2 = b0 + mj;
        n_v[0] = t1 + t2; n_v[1] = r_v[0]; n_v[2] = r_v[1]; n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1; n_v[5] = r_v[4]; n_v[6] = r_v[5]; n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v <= n_v;
        end
    end

    // bytes shift in big-endian, so after 128 beats r_w[0] holds bytes 0..7
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][55:0], r_w[i+1][63:56]};
            end
            r_w[15] <= {r_w[15][55:0], i_cmd.put_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= wi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_word(3'(i));
        end else if (i_cmd.reinit) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_word(3'(i));
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
            r_h[7] <= r_h[0];
        end
    end

    assign o_stat = '{fill: r_fill, full: r_full, bits: {r_cnt[60:0], 3'b000}};
    assign o_head = r_h[0];
endmodule

@@ rtl/s512_ctrl.sv @@
// Controller: input handshake, padding sequence, round count, digest output.
module s512_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    s512_in_if.sink         in_s,
    s512_out_if.source      out_s,
    input  s512_pkg::t_stat i_stat,
    input  logic [63:0]     i_head,
    output s512_pkg::t_cmd  o_cmd,
    output logic [6:0]      o_round
);
    import s512_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_FOLD  = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_START = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [6:0]  r_rnd, n_rnd;
    logic        r_fin, n_fin;
    logic        r_pad80, n_pad80;
    logic        r_lenblk, n_lenblk;
    logic [63:0] r_bits, n_bits;
    logic [2:0]  r_idx, n_idx;
    logic        acc, len_zone;
    logic [2:0]  lb;

    assign in_s.ready = (r_state == ST_IDLE);
    assign acc = in_s.valid && in_s.ready;
    assign len_zone = (i_stat.fill >= 7'(LEN_POS + 8));
    assign lb = i_stat.fill[2:0];

    always_comb begin
        n_state = r_state;
        n_rnd = r_rnd;
        n_fin = r_fin;
        n_pad80 = r_pad80;
        n_lenblk = r_lenblk;
        n_bits = r_bits;
        n_idx = r_idx;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.put = in_s.byte_present;
                    o_cmd.put_byte = in_s.data_byte;
                    o_cmd.count = in_s.byte_present;
                    n_fin = in_s.end_of_message;
                    n_pad80 = 1'b1;
                    if (in_s.byte_present && i_stat.fill == 7'(BLOCK_BYTES - 1)) begin
                        n_state = ST_START;
                    end else if (in_s.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.put = 1'b1;
                if (r_pad80) begin
                    // length fits in this block only if the marker lands before it
                    o_cmd.put_byte = PAD_BYTE;
                    n_bits = i_stat.bits;
                    n_lenblk = (i_stat.fill < 7'(LEN_POS));
                end else if (r_lenblk && len_zone) begin
                    o_cmd.put_byte = r_bits[8*(7-lb) +: 8];
                end
                n_pad80 = 1'b0;
                if (i_stat.fill == 7'(BLOCK_BYTES - 1)) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_rnd = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'd79) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_idx = '0;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_pad80) begin
                    n_state = ST_PAD;
                end else if (r_lenblk) begin
                    n_state = ST_OUT;
                end else begin
                    n_lenblk = 1'b1;
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_s.ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.reinit = 1'b1;
                        n_fin = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd <= '0;
            r_fin <= 1'b0;
            r_pad80 <= 1'b0;
            r_lenblk <= 1'b0;
            r_bits <= '0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_rnd <= n_rnd;
            r_fin <= n_fin;
            r_pad80 <= n_pad80;
            r_lenblk <= n_lenblk;
            r_bits <= n_bits;
            r_idx <= n_idx;
        end
    end

    assign out_s.valid = (r_state == ST_OUT);
    assign out_s.digest_word = i_head;
    assign out_s.word_index = r_idx;
    assign out_s.last_word = (r_idx == 3'd7);
    assign o_round = r_rnd;
endmodule

@@ rtl/sha512_stream_hash.sv @@
// Top level: streaming SHA-512 engine.
// One byte beat is taken per cycle while a block fills. A full block holds
// the input while it is compressed (load, 80 rounds with one shared round unit, fold).
// At end of message padding writes one byte per cycle up to the block end,
// with one extra compression when fewer than 17 bytes remain; then eight
// digest beats follow, one per cycle when the sink is ready.
module sha512_stream_hash (
    input  logic i_clk,
    input  logic i_rst_n,
    s512_in_if.sink    in_s,
    s512_out_if.source out_s
);
    import s512_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic [6:0]  rnd;
    logic [63:0] head;

    s512_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_s(in_s), .out_s(out_s),
        .i_stat(stat), .i_head(head), .o_cmd(cmd), .o_round(rnd)
    );

    s512_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_round(rnd),
        .o_stat(stat), .o_head(head)
    );
endmodule

@@ rtl/s512_checker.sv @@
// Port checker for the SHA-512 engine, bound to the top level.
`include "assert_macros.svh"
module s512_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last_word
);
    `ASSERT_CLK(a_last_idx, i_clk, i_rst_n,
        out_valid |-> (last_word == (word_index == 3'd7)), "last_word mismatch")
    `ASSERT_CLK(a_no_overlap, i_clk, i_rst_n,
        out_valid |-> !in_ready, "input taken during digest")
    `ASSERT_CLK(a_idx_step, i_clk, i_rst_n,
        (out_valid && out_ready && !last_word) |=>
        (out_valid && word_index == $past(word_index) + 3'd1), "digest index skipped")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n,
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)),
        "digest beat dropped while stalled")
    `ASSERT_CLK_NR(a_rst, i_clk, !i_rst_n |=> !out_valid, "output valid after reset")
endmodule

bind sha512_stream_hash s512_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(in_s.ready),
    .out_valid(out_s.valid), .out_ready(out_s.ready),
    .word_index(out_s.word_index), .last_word(out_s.last_word)
);

@@ test/sha512_stream_hash_check.sv @@
// Checker: watches both channels, predicts digests and compares.
`timescale 1ns / 1ps
module sha512_stream_hash_check (
    input  logic i_clk,
    input  logic i_rst_n,
    s512_in_if.sink    in_m,
    s512_out_if.sink   out_m,
    output int         o_errors,
    output int         o_pending
);
    import s512_pkg::*;

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    t_digest_beat digest_q[$];
    t_word        chain[8];
    logic [7:0]   block[128];
    int unsigned  fill;
    logic [63:0]  byte_count;

    function automatic t_word ror64(input t_word x, input int s);
        return (x >> s) | (x << (64 - s));
    endfunction

    function automatic t_word iv_word(input int i);
        t_word iv[8] = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
                         64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
                         64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                         64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
        return iv[i];
    endfunction

    task automatic compress_block();
        t_word w[80];
        t_word v[8];
        t_word t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = '0;
            for (int j = 0; j < 8; j++) w[i] = (w[i] << 8) | block[i * 8 + j];
        end
        for (int i = 16; i < 80; i++)
            w[i] = w[i-16] + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7))
                 + w[i-7] + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 80; i++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[6:0]) + w[i];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic append_byte(input logic [7:0] b);
        block[fill] = b;
        fill++;
        if (fill == 128) begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) chain[i] = iv_word(i);
        fill = 0;
        byte_count = '0;
    endtask

    task automatic absorb_beat(input logic [7:0] b, input logic present, input logic eom);
        logic [63:0] bits;
        if (present) begin
            append_byte(b);
            byte_count++;
        end
        if (eom) begin
            bits = byte_count << 3;
            append_byte(PAD_BYTE);
            while (fill != LEN_POS) append_byte(8'h00);
            for (int i = 0; i < 8; i++) append_byte(8'h00);
            for (int i = 0; i < 8; i++) append_byte(bits[63 - 8 * i -: 8]);
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{chain[i], i[2:0], i == 7});
            restart_message();
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        restart_message();
    end

    always @(posedge i_clk) begin
        t_digest_beat e;
        if (i_rst_n) begin
            if (in_m.valid && in_m.ready)
                absorb_beat(in_m.data_byte, in_m.byte_present, in_m.end_of_message);
            if (out_m.valid && out_m.ready) begin
                if (digest_q.size() == 0) begin
                    report("unexpected digest beat", out_m.digest_word, 64'd0);
                end else begin
                    e = digest_q.pop_front();
                    if (out_m.digest_word !== e.word)
                        report("digest_word", out_m.digest_word, e.word);
                    if (out_m.word_index !== e.index)
                        report("word_index", 64'(out_m.word_index), 64'(e.index));
                    if (out_m.last_word !== e.last)
                        report("last_word", 64'(out_m.last_word), 64'(e.last));
                end
            end
            o_pending = digest_q.size();
        end
    end
endmodule

@@ test/sha512_stream_hash_test.sv @@
// Testbench top: drives byte beats and digest backpressure, gives the verdict.
`timescale 1ns / 1ps
module sha512_stream_hash_test;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   idle_cycles = 0;
    int   sink_wait = 0;
    int   sent = 0;
    bit   timed_out = 1'b0;
    bit   burst;

    s512_in_if  in_s ();
    s512_out_if out_s ();

    sha512_stream_hash dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .in_s(in_s), .out_s(out_s));
    sha512_stream_hash_check chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .in_m(in_s),
        .out_m(out_s), .o_errors(errors), .o_pending(pending));

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_s.valid = 1'b0;
        in_s.data_byte = '0;
        in_s.byte_present = 1'b0;
        in_s.end_of_message = 1'b0;
        out_s.ready = 1'b0;
    end

    // digest sink draws a random wait before each beat and raises ready when it runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_s.ready <= 1'b0;
            sink_wait = $urandom_range(0, 6);
        end else if (out_s.ready && out_s.valid) begin
            sink_wait = $urandom_range(0, 6);
            out_s.ready <= (sink_wait == 0);
        end else if (!out_s.ready) begin
            if (sink_wait > 0) sink_wait--;
            out_s.ready <= (sink_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready))) begin
            idle_cycles++;
            if (idle_cycles >= 20000) begin
                timed_out = 1'b1;
                $display("status: fail");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic present, input logic eom);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_s.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_s.valid <= 1'b1;
        in_s.data_byte <= b;
        in_s.byte_present <= present;
        in_s.end_of_message <= eom;
        do @(posedge i_clk); while (!in_s.ready);
        sent++;
    endtask

    task automatic send_message(input int len, input bit tail_byte);
        for (int i = 0; i < len - 1; i++) begin
            if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, 1'b0);
        end
        if (len > 0) send_beat(8'($urandom), tail_byte, 1'b1);
        else send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        burst = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, idle beat, extreme bytes, pad boundaries
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7f, 1'b0, 1'b1);
        burst = 1'b1;
        for (int i = 0; i < 111; i++) send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'haa, 1'b1, 1'b1);
        send_message(113, 1'b1);
        burst = 1'b0;
        send_message(128, 1'b1);
        while (sent < 460) begin
            int len;
            burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(100, 135);
                2: len = $urandom_range(240, 260);
                default: len = $urandom_range(9, 99);
            endcase
            if (len > 459 - sent) len = 459 - sent;
            send_message(len, 1'($urandom_range(0, 1)));
        end
        in_s.valid <= 1'b0;
        burst = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && !timed_out) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
